/* design/bmff_pkg.sv */
// ----------------------------------------------------------------------------
// bmff_pkg
// shared widths, codes and reset values of the first-fit bitmap allocator
// ----------------------------------------------------------------------------
package bmff_pkg;

    localparam int NUM_W      = 14;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 14;

    typedef logic [NUM_W-1:0]    t_num;
    typedef logic [STATUS_W-1:0] t_status;

    // request commands
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // response status codes
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_RANGE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_START = 1'b1;

    // reset values of the configuration registers
    localparam t_num TOTAL_RST = 14'd8192;
    localparam int   START_RST = 8192;

endpackage

/* design/bmff_req_if.sv */
// ----------------------------------------------------------------------------
// bmff_req_if
// request channel: allocate or free command with a one-based item number
// ----------------------------------------------------------------------------
interface bmff_req_if;

    logic               valid;
    logic               ready;
    logic               cmd;
    bmff_pkg::t_num     item_number;

    modport source (output valid, output cmd, output item_number, input ready);
    modport sink   (input valid, input cmd, input item_number, output ready);

endinterface

/* design/bmff_rsp_if.sv */
// ----------------------------------------------------------------------------
// bmff_rsp_if
// response channel: granted item, status and free counter
// ----------------------------------------------------------------------------
interface bmff_rsp_if;

    logic               valid;
    logic               ready;
    bmff_pkg::t_num     granted_number;
    bmff_pkg::t_status  status;
    bmff_pkg::t_num     free_count;

    modport source (output valid, output granted_number, output status, output free_count,
                    input ready);
    modport sink   (input valid, input granted_number, input status, input free_count,
                    output ready);

endinterface

/* design/bmff_ram.sv */
// ----------------------------------------------------------------------------
// bmff_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module bmff_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/bmff_ffs.sv */
// ----------------------------------------------------------------------------
// bmff_ffs
// find-first-set unit: lowest set bit of one map word
// ----------------------------------------------------------------------------
module bmff_ffs #(
    parameter int WIDTH = 32
) (
    input  logic [WIDTH-1:0]         i_vec,
    output logic                     o_found,
    output logic [$clog2(WIDTH)-1:0] o_index
);

    localparam int IW = $clog2(WIDTH);

    always_comb begin
        o_index = '0;
        for (int b = WIDTH - 1; b >= 0; b--) begin
            if (i_vec[b]) begin
                o_index = IW'(b);
            end
        end
    end

    assign o_found = |i_vec;

endmodule

/* design/bitmap_first_fit_allocator.sv */
// ----------------------------------------------------------------------------
// bitmap_first_fit_allocator
// first-fit item allocator over a used-bit map held in one ram
// ----------------------------------------------------------------------------
// requests arrive on i_req (cmd 0 allocate, 1 free item_number), one response
// per request leaves on o_rsp with granted_number, status and free_count.
// one request is in work at a time; i_req.ready is high only when idle.
// allocate scans the map one word per cycle through the find-first-set
// unit and stops at the first word with a clear bit, or answers full after
// the last word. free runs a reciprocal multiply for the word index, then the
// remainder and the ram read, then the write back. an out of range free or an
// allocate with a size of zero goes straight to the response.
// the response sits in an output register; while o_rsp is stalled the block
// finishes its current request and holds it until the register frees up.
// after reset the map is cleared one word per cycle, all MAP_BITS / WORD_BITS
// words rounded up, with i_req.ready low; config writes are taken meanwhile.
// config is written with i_cfg_we, i_cfg_idx, i_cfg_data; the user is to
// write it only while idle, the block itself does not enforce this.
// ----------------------------------------------------------------------------
module bitmap_first_fit_allocator #(
    parameter int MAP_BITS  = 8192,
    parameter int WORD_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    bmff_req_if.sink                            i_req,
    bmff_rsp_if.source                          o_rsp,
    input  logic                                i_cfg_we,
    input  logic [bmff_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [bmff_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int NUM_W     = bmff_pkg::NUM_W;
    localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int WA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int CNT_W     = $clog2(MAP_BITS + 1);
    localparam int IX_W      = $clog2(MAP_BITS);
    localparam int BASE_W    = CNT_W + 1;
    localparam int CMP_W     = ((CNT_W > NUM_W) ? CNT_W : NUM_W) + 1;
    localparam int SH        = IX_W + BIT_W;
    localparam int RC_W      = IX_W + 2;
    localparam int PW        = IX_W + RC_W + BIT_W + 2;
    localparam longint RECIP = ((64'd1 << SH) + WORD_BITS - 1) / WORD_BITS;
    localparam int FREE_RST  = (bmff_pkg::START_RST > MAP_BITS) ? MAP_BITS
                                                                 : bmff_pkg::START_RST;

    localparam logic [RC_W-1:0]  RECIP_C    = RC_W'(RECIP);
    localparam logic [CNT_W-1:0] MAP_BITS_C = CNT_W'(MAP_BITS);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_FDIV = 3'd3;
    localparam logic [2:0] S_FRD  = 3'd4;
    localparam logic [2:0] S_FWR  = 3'd5;
    localparam logic [2:0] S_RESP = 3'd6;

    logic [2:0]                r_state, n_state;
    logic [NUM_W-1:0]          r_total;
    logic [CNT_W-1:0]          r_free;
    logic [WA_W-1:0]           r_clr;
    logic [WA_W-1:0]           r_rd_word;
    logic [WA_W-1:0]           r_ck_word;
    logic                      r_ck_valid;
    logic [BASE_W-1:0]         r_ck_base;
    logic [IX_W-1:0]           r_idx;
    logic [WA_W-1:0]           r_word;
    logic [BIT_W-1:0]          r_bit;
    bmff_pkg::t_num            r_res_granted;
    bmff_pkg::t_status         r_res_status;
    logic                      r_out_valid;
    bmff_pkg::t_num            r_out_granted;
    bmff_pkg::t_status         r_out_status;
    bmff_pkg::t_num            r_out_free;

    logic [CNT_W-1:0]          w_size;
    logic [CMP_W-1:0]          w_req_num;
    logic                      w_range_bad;
    logic                      w_accept;
    logic                      w_rsp_load;
    logic [PW-1:0]             w_prod;
    logic [IX_W:0]             w_word_base;
    logic [BIT_W-1:0]          w_rem;
    logic [BASE_W-1:0]         w_avail;
    logic [WORD_BITS-1:0]      w_mask;
    logic [WORD_BITS-1:0]      w_open;
    logic                      w_found;
    logic [BIT_W-1:0]          w_first;
    logic                      w_last;
    logic                      w_grant;
    logic [BASE_W-1:0]         w_grant_num;
    logic [CMP_W-1:0]          w_cfg_ext;

    logic                      w_ram_we;
    logic [WA_W-1:0]           w_ram_waddr;
    logic [WORD_BITS-1:0]      w_ram_wdata;
    logic [WA_W-1:0]           w_ram_raddr;
    logic [WORD_BITS-1:0]      w_ram_rdata;

    bmff_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    bmff_ffs #(
        .WIDTH (WORD_BITS)
    ) u_ffs (
        .i_vec   (w_open),
        .o_found (w_found),
        .o_index (w_first)
    );

    // effective size and range check
    always_comb begin
        if (CMP_W'(r_total) > CMP_W'(MAP_BITS)) begin
            w_size = MAP_BITS_C;
        end else begin
            w_size = CNT_W'(r_total);
        end
    end

    assign w_req_num   = CMP_W'(i_req.item_number);
    assign w_range_bad = (w_req_num == '0) || (w_req_num > CMP_W'(w_size));
    assign w_accept    = i_req.valid && (r_state == S_IDLE);
    assign w_rsp_load  = (r_state == S_RESP) && (!r_out_valid || o_rsp.ready);

    // word index and bit of a free by reciprocal multiply
    assign w_prod      = PW'(r_idx) * PW'(RECIP_C);
    assign w_word_base = (IX_W + 1)'(r_word) * (IX_W + 1)'(WORD_BITS);
    assign w_rem       = BIT_W'((IX_W + 1)'(r_idx) - w_word_base);

    // scan: clear bits of the checked word below the effective size
    assign w_avail = BASE_W'(w_size) - r_ck_base;

    always_comb begin
        for (int b = 0; b < WORD_BITS; b++) begin
            w_mask[b] = (BASE_W'(b) < w_avail);
        end
    end

    assign w_open      = ~w_ram_rdata & w_mask;
    assign w_last      = (r_ck_base + BASE_W'(WORD_BITS)) >= BASE_W'(w_size);
    assign w_grant     = (r_state == S_SCAN) && r_ck_valid && w_found;
    assign w_grant_num = r_ck_base + BASE_W'(w_first) + BASE_W'(1);
    assign w_cfg_ext   = CMP_W'(i_cfg_data);

    always_comb begin
        n_state     = r_state;
        w_ram_we    = 1'b0;
        w_ram_waddr = r_ck_word;
        w_ram_wdata = w_ram_rdata | (WORD_BITS'(1) << w_first);
        w_ram_raddr = r_word;
        unique case (r_state)
            S_CLR: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = r_clr;
                w_ram_wdata = '0;
                if (r_clr == WA_W'(MAP_WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    if (i_req.cmd == bmff_pkg::CMD_FREE) begin
                        n_state = w_range_bad ? S_RESP : S_FDIV;
                    end else begin
                        n_state = (w_size == '0) ? S_RESP : S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                w_ram_raddr = r_rd_word;
                if (r_ck_valid) begin
                    if (w_found) begin
                        w_ram_we = 1'b1;
                        n_state  = S_RESP;
                    end else if (w_last) begin
                        n_state = S_RESP;
                    end
                end
            end
            S_FDIV: begin
                n_state = S_FRD;
            end
            S_FRD: begin
                n_state = S_FWR;
            end
            S_FWR: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = r_word;
                w_ram_wdata = w_ram_rdata & ~(WORD_BITS'(1) << r_bit);
                n_state     = S_RESP;
            end
            S_RESP: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLR;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_ck_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_total     <= bmff_pkg::TOTAL_RST;
            r_free      <= CNT_W'(FREE_RST);
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) begin
                r_clr <= r_clr + WA_W'(1);
            end
            r_ck_valid <= (r_state == S_SCAN);
            if (w_rsp_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we && (i_cfg_idx == bmff_pkg::REG_TOTAL)) begin
                r_total <= i_cfg_data;
            end
            if (i_cfg_we && (i_cfg_idx == bmff_pkg::REG_START)) begin
                if (w_cfg_ext > CMP_W'(MAP_BITS)) begin
                    r_free <= MAP_BITS_C;
                end else begin
                    r_free <= CNT_W'(i_cfg_data);
                end
            end else if (w_grant && (r_free != '0)) begin
                r_free <= r_free - CNT_W'(1);
            end else if ((r_state == S_FWR) && (r_free != MAP_BITS_C)) begin
                r_free <= r_free + CNT_W'(1);
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_idx         <= IX_W'(w_req_num - CMP_W'(1));
            r_rd_word     <= '0;
            r_ck_word     <= '0;
            r_ck_base     <= '0;
            r_res_granted <= '0;
            if (i_req.cmd == bmff_pkg::CMD_FREE) begin
                r_res_status <= w_range_bad ? bmff_pkg::ST_RANGE : bmff_pkg::ST_OK;
            end else begin
                r_res_status <= bmff_pkg::ST_FULL;
            end
        end
        if (r_state == S_SCAN) begin
            r_rd_word <= r_rd_word + WA_W'(1);
            if (r_ck_valid && !w_found) begin
                r_ck_word <= r_ck_word + WA_W'(1);
                r_ck_base <= r_ck_base + BASE_W'(WORD_BITS);
            end
        end
        if (w_grant) begin
            r_res_granted <= NUM_W'(w_grant_num);
            r_res_status  <= bmff_pkg::ST_OK;
        end
        if (r_state == S_FDIV) begin
            r_word <= WA_W'(w_prod >> SH);
        end
        if (r_state == S_FRD) begin
            r_bit <= w_rem;
        end
        if (w_rsp_load) begin
            r_out_granted <= r_res_granted;
            r_out_status  <= r_res_status;
            r_out_free    <= NUM_W'(r_free);
        end
    end

    assign i_req.ready          = (r_state == S_IDLE);
    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.granted_number = r_out_granted;
    assign o_rsp.status         = r_out_status;
    assign o_rsp.free_count     = r_out_free;

endmodule

/* design/bmff_chk.sv */
// ----------------------------------------------------------------------------
// bmff_chk
// port-level checks of the first-fit bitmap allocator, bound to the top level
// ----------------------------------------------------------------------------
module bmff_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_req_valid,
    input logic               i_req_ready,
    input logic               i_rsp_valid,
    input logic               i_rsp_ready,
    input bmff_pkg::t_num     i_rsp_granted_number,
    input bmff_pkg::t_status  i_rsp_status,
    input bmff_pkg::t_num     i_rsp_free_count
);

    // one request in work at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request taken while a request is in work");

    // stalled response holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_rsp_granted_number)
        && $stable(i_rsp_status) && $stable(i_rsp_free_count)))
        else $error("stalled response changed");

    // nothing granted unless status is ok
    a_grant_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && (i_rsp_status != bmff_pkg::ST_OK)) |-> (i_rsp_granted_number == '0))
        else $error("item granted with a failing status");

    // map clear runs after reset, nothing pending
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!i_req_ready && !i_rsp_valid))
        else $error("ready or response right after reset");

endmodule

bind bitmap_first_fit_allocator bmff_chk u_bmff_chk (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_req_valid          (i_req.valid),
    .i_req_ready          (i_req.ready),
    .i_rsp_valid          (o_rsp.valid),
    .i_rsp_ready          (o_rsp.ready),
    .i_rsp_granted_number (o_rsp.granted_number),
    .i_rsp_status         (o_rsp.status),
    .i_rsp_free_count     (o_rsp.free_count)
);
